// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define VSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/vsd_pkg.sv -----
package vsd_pkg;

  localparam int AGC_WINDOW_DEF = 100;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 22;
  localparam int LIMIT_W    = 23;
  localparam int SINCE_W    = 17;
  localparam int LINE_W     = 10;
  localparam int LEN_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // 5*mag+2 and its exact divide-by-3 through a reciprocal
  localparam int X_W       = 18;
  localparam int QUOT_W    = 16;
  localparam int DIV3_SHIFT = 19;
  localparam logic [X_W-1:0] DIV3_RECIP = 18'd174763;

  localparam logic [6:0] AGC_DIVISOR = 7'd100;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

  localparam logic [LEN_W-1:0]  LINE_LEN_RST     = 16'd864;
  localparam logic [LINE_W-1:0] FRAME_HEIGHT_RST = 10'd625;
  localparam logic              INTERLACED_RST   = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LEN     = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_INTERLACED   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0]  line_len;
    logic [LINE_W-1:0] frame_height;
    logic              interlaced;
  } cfg_t;

  // Classified sample: magnitude, sign and the smallest reference sum
  // that no longer triggers the threshold for this magnitude.
  typedef struct packed {
    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic [LIMIT_W-1:0] limit;
  } item_t;

  typedef struct packed {
    logic push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic locked;
    logic hsync;
    logic field;
  } result_t;

endpackage

// ----- sv/vsd_if.sv -----
interface vsd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vsd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface vsd_out_if;
  logic valid;
  logic ready;
  logic locked;
  logic hsync;
  logic field;

  modport source (output valid, output locked, output hsync, output field, input ready);
  modport sink (input valid, input locked, input hsync, input field, output ready);
endinterface

// ----- sv/vsd_front.sv -----
module vsd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic signed [vsd_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                                in_ready_o,
  input  logic [vsd_pkg::QCNT_W-1:0]          q_count_i,
  output vsd_pkg::push_t                      push_o
);

  logic                              v1_q, v2_q;
  logic [vsd_pkg::MAG_W-1:0]         mag1_q, mag2_q;
  logic                              neg1_q, neg2_q;
  logic [vsd_pkg::X_W-1:0]           x1_q;
  logic [vsd_pkg::QUOT_W-1:0]        quot2_q;
  logic [vsd_pkg::MAG_W-1:0]         mag;
  logic [vsd_pkg::X_W-1:0]           x;
  logic [2*vsd_pkg::X_W-1:0]         prod;
  logic [vsd_pkg::QCNT_W:0]          occ;
  logic                              accept;

  // Items in flight plus queued must leave room for one more.
  assign occ = {1'b0, q_count_i} + (vsd_pkg::QCNT_W+1)'(v1_q) + (vsd_pkg::QCNT_W+1)'(v2_q);
  assign in_ready_o = occ < (vsd_pkg::QCNT_W+1)'(vsd_pkg::QUEUE_DEPTH);
  assign accept = in_valid_i & in_ready_o;

  assign mag  = in_sample_i[vsd_pkg::SAMPLE_W-1] ? (~in_sample_i + 16'd1) : in_sample_i;
  assign x    = ({2'b00, mag} << 2) + {2'b00, mag} + 18'd2;
  assign prod = x1_q * vsd_pkg::DIV3_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q  <= mag;
    neg1_q  <= in_sample_i[vsd_pkg::SAMPLE_W-1];
    x1_q    <= x;
    mag2_q  <= mag1_q;
    neg2_q  <= neg1_q;
    quot2_q <= prod[vsd_pkg::DIV3_SHIFT +: vsd_pkg::QUOT_W];
  end

  always_comb begin
    push_o.push       = v2_q;
    push_o.item.mag   = mag2_q;
    push_o.item.neg   = neg2_q;
    push_o.item.limit = vsd_pkg::LIMIT_W'(quot2_q) * vsd_pkg::LIMIT_W'(vsd_pkg::AGC_DIVISOR);
  end

endmodule

// ----- sv/vsd_queue.sv -----
module vsd_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vsd_pkg::push_t             push_i,
  input  logic                       pop_i,
  output vsd_pkg::item_t             item_o,
  output logic [vsd_pkg::QCNT_W-1:0] count_o
);

  vsd_pkg::item_t                entry_q [vsd_pkg::QUEUE_DEPTH];
  logic [vsd_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [vsd_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [vsd_pkg::QCNT_W-1:0]    count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i.push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + vsd_pkg::QCNT_W'(push_i.push) - vsd_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      entry_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign item_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- sv/vsd_back.sv -----
module vsd_back #(
  parameter int AGC_WINDOW = vsd_pkg::AGC_WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vsd_pkg::cfg_t              cfg_i,
  input  logic [vsd_pkg::QCNT_W-1:0] q_count_i,
  input  vsd_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output vsd_pkg::result_t           result_o
);

  localparam int PH_W = $clog2(AGC_WINDOW);

  logic [vsd_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [vsd_pkg::SUM_W-1:0]   sref_q, sref_d;
  logic [PH_W-1:0]             phase_q, phase_d;
  logic [vsd_pkg::SINCE_W-1:0] since_q, since_d;
  logic [vsd_pkg::LINE_W-1:0]  line_q, line_d;
  logic                        field_q, field_d;
  logic                        lock_q, lock_d;
  logic                        out_valid_q, out_valid_d;
  vsd_pkg::result_t            result_q, result_d;

  logic [vsd_pkg::SUM_W:0]     sum_ext;
  logic [vsd_pkg::SUM_W-1:0]   sum_sat;
  logic [vsd_pkg::SUM_W-1:0]   sref;
  logic                        agc_update;
  logic                        below;
  logic                        holdoff_done;
  logic                        detect;
  logic [vsd_pkg::LINE_W:0]    line_inc;
  logic [PH_W:0]               phase_inc;
  logic [vsd_pkg::SINCE_W-1:0] since_inc;

  assign pop_o = (q_count_i != '0) & (~out_valid_q | out_ready_i);

  always_comb begin
    sum_ext = {1'b0, sum_q} + (vsd_pkg::SUM_W+1)'(item_i.mag);
    sum_sat = sum_ext[vsd_pkg::SUM_W] ? vsd_pkg::SUM_MAX : sum_ext[vsd_pkg::SUM_W-1:0];
    agc_update = (phase_q == '0) && (sum_sat != '0);
    // The threshold is kept as the window sum that set it; a negative
    // sample crosses it exactly when that sum is below the item's limit.
    sref  = agc_update ? sum_sat : sref_q;
    below = item_i.neg && ((vsd_pkg::LIMIT_W'(sref)) < item_i.limit);
    holdoff_done = since_q > vsd_pkg::SINCE_W'(cfg_i.line_len[vsd_pkg::LEN_W-1:1]);
    detect = below && holdoff_done;

    line_inc  = {1'b0, line_q} + 1'b1;
    phase_inc = {1'b0, phase_q} + 1'b1;
    since_inc = (since_q < vsd_pkg::SINCE_MAX) ? since_q + 1'b1 : since_q;

    sum_d   = agc_update ? '0 : sum_sat;
    sref_d  = sref;
    line_d  = line_q;
    field_d = field_q;
    lock_d  = lock_q;
    if (detect) begin
      if (line_inc >= {1'b0, cfg_i.frame_height}) begin
        line_d  = '0;
        field_d = field_q ^ cfg_i.interlaced;
      end else begin
        line_d = line_inc[vsd_pkg::LINE_W-1:0];
      end
      since_d = '0;
      phase_d = '0;
      lock_d  = 1'b1;
    end else begin
      since_d = since_inc;
      phase_d = (phase_inc >= (PH_W+1)'(AGC_WINDOW)) ? '0 : phase_inc[PH_W-1:0];
      if (since_inc > {cfg_i.line_len, 1'b0}) begin
        lock_d = 1'b0;
      end
    end

    result_d.locked = lock_d;
    result_d.hsync  = detect;
    result_d.field  = field_q;

    out_valid_d = pop_o | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sref_q      <= '0;
      phase_q     <= '0;
      since_q     <= '0;
      line_q      <= '0;
      field_q     <= 1'b0;
      lock_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        sum_q   <= sum_d;
        sref_q  <= sref_d;
        phase_q <= phase_d;
        since_q <= since_d;
        line_q  <= line_d;
        field_q <= field_d;
        lock_q  <= lock_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ----- sv/video_sync_detector_agc.sv -----
// Path: a sample passes two classify stages, one queue slot and one output
// register on its way from input to output.
// Throughput: one sample per cycle while out_ready holds, set by the state
// update in the back end; input ready drops only when the queue and the two
// classify stages together hold four samples.
// Reset: asynchronous, active low; clears all sync/AGC state and loads
module video_sync_detector_agc #(
  parameter int AGC_WINDOW = vsd_pkg::AGC_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  vsd_in_if.sink                         in_if,
  vsd_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [vsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vsd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // the register defaults. No clearing pass.

  vsd_pkg::cfg_t                cfg_q;
  vsd_pkg::push_t               push;
  vsd_pkg::item_t               head;
  logic [vsd_pkg::QCNT_W-1:0]   q_count;
  logic                         pop;
  vsd_pkg::result_t             result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_len     <= vsd_pkg::LINE_LEN_RST;
      cfg_q.frame_height <= vsd_pkg::FRAME_HEIGHT_RST;
      cfg_q.interlaced   <= vsd_pkg::INTERLACED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vsd_pkg::REG_LINE_LEN:     cfg_q.line_len     <= cfg_data_i;
        vsd_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[vsd_pkg::LINE_W-1:0];
        vsd_pkg::REG_INTERLACED:   cfg_q.interlaced   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_sample_i (in_if.sample),
    .in_ready_o  (in_if.ready),
    .q_count_i   (q_count),
    .push_o      (push)
  );

  vsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .item_o  (head),
    .count_o (q_count)
  );

  vsd_back #(
    .AGC_WINDOW (AGC_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_count_i   (q_count),
    .item_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .result_o    (result)
  );

  assign out_if.locked = result.locked;
  assign out_if.hsync  = result.hsync;
  assign out_if.field  = result.field;

endmodule

// ----- sv/vsd_checker.sv -----
`include "assert_macros.svh"

module vsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic locked_i,
  input logic hsync_i,
  input logic field_i
);

  logic [3:0] pending_q;
  logic       out_stall;
  logic [2:0] flags;

  assign out_stall = out_valid_i && !out_ready_i;
  assign flags     = {locked_i, hsync_i, field_i};

  // Track samples taken whose results have not yet been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_valid_i & in_ready_i) - 4'(out_valid_i & out_ready_i);
    end
  end

  `VSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(flags))
  `VSD_ASSERT_IMPLY(a_start_locks, clk_i, rst_ni, out_valid_i && hsync_i, locked_i)
  `VSD_ASSERT_IMPLY(a_out_has_input, clk_i, rst_ni, out_valid_i, pending_q != 4'd0)
  `VSD_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, pending_q == 4'd0, in_ready_i)

endmodule

bind video_sync_detector_agc vsd_checker u_vsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .locked_i    (out_if.locked),
  .hsync_i     (out_if.hsync),
  .field_i     (out_if.field)
);
